// ===== rtl/core/lmcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lmcs_pkg
// Shared types and constants of the logistic map convergence scan unit.
// ----------------------------------------------------------------------------
package lmcs_pkg;

  // Multiplier digit, rate and field widths
  localparam int unsigned DIGIT_BITS     = 32;
  localparam int unsigned RATE_BITS      = 32;
  localparam int unsigned RATE_FRAC      = 29;
  localparam int unsigned INDEX_BITS     = 16;
  localparam int unsigned STEPS_BITS     = 16;
  localparam int unsigned LIMIT_BITS     = 20;
  localparam int unsigned TOL_BITS       = 32;
  localparam int unsigned FINAL_BITS     = 32;
  localparam int unsigned PROD_BITS      = INDEX_BITS + RATE_BITS;
  localparam int unsigned CFG_DATA_BITS  = 32;
  localparam int unsigned CFG_INDEX_BITS = 3;

  localparam logic [RATE_BITS-1:0] RATE_MAX = 32'h8000_0000;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SWEEP_LOW  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SWEEP_HIGH = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SWEEP_STEPS = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ITER_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TOLERANCE  = 3'd4;

  // Configuration reset values
  localparam logic [RATE_BITS-1:0]  RST_SWEEP_LOW   = 32'd1503238554;
  localparam logic [RATE_BITS-1:0]  RST_SWEEP_HIGH  = 32'h8000_0000;
  localparam logic [STEPS_BITS-1:0] RST_SWEEP_STEPS = 16'd100;
  localparam logic [LIMIT_BITS-1:0] RST_ITER_LIMIT  = 20'd1000;
  localparam logic [TOL_BITS-1:0]   RST_TOLERANCE   = 32'd43;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_START,
    S_DIV_WAIT,
    S_RATE,
    S_TEST,
    S_SQUARE,
    S_SCALE,
    S_DONE
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;      // item accepted: form idx * |high - low|
    logic div_start;    // start rate division
    logic rate_load;    // latch rate, set up first attempt
    logic step_start;   // begin a map step: last <= x, count up, square x
    logic scale_start;  // second product r * p
    logic x_update;     // store saturated new x
    logic restart;      // begin second attempt from the mean
    logic out_load;     // load result registers
  } lmcs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic below_tol;
    logic at_limit;
    logic tried;
  } lmcs_status_t;

endpackage

// ===== rtl/core/logistic_map_convergence_scan_unit.sv =====
// ----------------------------------------------------------------------------
// logistic_map_convergence_scan_unit
// Sequence: the rate is formed through the bit-serial divider, then each attempt
// runs a test state and map steps, each a square and a scale product on the
// digit-serial multiplier (ND = ceil(X_FRACTION_BITS/32) digits), then a load.
// Throughput: one item at a time, set by the map loop on the shared multiplier.
// A new item is taken while the previous result still waits at the output.
// Reset: configuration registers take their defaults, no item is in flight.
// ----------------------------------------------------------------------------
module logistic_map_convergence_scan_unit #(
  parameter int unsigned X_FRACTION_BITS = 32,
  parameter int unsigned COUNT_BITS      = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lmcs_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [lmcs_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lmcs_pkg::INDEX_BITS-1:0]     point_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lmcs_pkg::RATE_BITS-1:0]      rate_value_o,
  output logic [lmcs_pkg::LIMIT_BITS-1:0]     first_count_o,
  output logic                                second_tried_o,
  output logic [lmcs_pkg::LIMIT_BITS-1:0]     second_count_o,
  output logic                                converged_o,
  output logic [lmcs_pkg::FINAL_BITS-1:0]     final_value_o
);
  import lmcs_pkg::*;

  lmcs_cmd_t    cmd;
  lmcs_status_t status;

  lmcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lmcs_datapath #(
    .X_FRACTION_BITS (X_FRACTION_BITS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .point_index_i  (point_index_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .rate_value_o   (rate_value_o),
    .first_count_o  (first_count_o),
    .second_tried_o (second_tried_o),
    .second_count_o (second_count_o),
    .converged_o    (converged_o),
    .final_value_o  (final_value_o)
  );

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("result loaded over a pending item");

  // New x only from a finished product
  a_x_from_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.x_update |-> status.mul_done)
    else $error("x updated before the product finished");

  // Restart only once, and only at the iteration limit
  a_restart_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.restart |-> (status.at_limit && !status.tried))
    else $error("restart outside the first attempt limit");

  // One item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while one is in work");

endmodule

// ===== rtl/core/lmcs_mul.sv =====
// ----------------------------------------------------------------------------
// lmcs_mul
// Digit-serial unsigned multiplier: one 32x32 partial product per cycle,
// registered, then shifted into a wide accumulator.
// ----------------------------------------------------------------------------
module lmcs_mul #(
  parameter int unsigned NUM_DIGITS = 1
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  input  logic [NUM_DIGITS*lmcs_pkg::DIGIT_BITS-1:0] a_i,
  input  logic [NUM_DIGITS*lmcs_pkg::DIGIT_BITS-1:0] b_i,
  output logic                                       done_o,
  output logic [2*NUM_DIGITS*lmcs_pkg::DIGIT_BITS-1:0] product_o
);
  import lmcs_pkg::*;

  localparam int unsigned OPW = NUM_DIGITS * DIGIT_BITS;
  localparam int unsigned PW  = 2 * OPW;
  localparam int unsigned CW  = $clog2(NUM_DIGITS + 1);
  localparam int unsigned SHW = $clog2(2 * NUM_DIGITS);

  logic [OPW-1:0]          a_q, b_q;
  logic [CW-1:0]           i_q, j_q;
  logic                    run_q, pv_q, plast_q, done_q;
  logic [2*DIGIT_BITS-1:0] prod_q;
  logic [SHW-1:0]          sh_q;
  logic [PW-1:0]           acc_q;
  logic [DIGIT_BITS-1:0]   a_dig, b_dig;
  logic                    last_pair, j_last;

  // Digit selection
  always_comb begin
    a_dig     = DIGIT_BITS'(a_q >> (DIGIT_BITS * i_q));
    b_dig     = DIGIT_BITS'(b_q >> (DIGIT_BITS * j_q));
    j_last    = (j_q == CW'(NUM_DIGITS - 1));
    last_pair = j_last && (i_q == CW'(NUM_DIGITS - 1));
  end

  // Sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      pv_q    <= 1'b0;
      plast_q <= 1'b0;
      done_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      pv_q    <= run_q && !start_i;
      plast_q <= run_q && last_pair && !start_i;
      done_q  <= pv_q && plast_q;
      if (start_i) begin
        run_q <= 1'b1;
        i_q   <= '0;
        j_q   <= '0;
      end else if (run_q) begin
        if (j_last) begin
          j_q <= '0;
          i_q <= i_q + CW'(1);
        end else begin
          j_q <= j_q + CW'(1);
        end
        if (last_pair) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // Partial products and accumulation
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + (PW'(prod_q) << (DIGIT_BITS * sh_q));
    end
    if (run_q) begin
      prod_q <= a_dig * b_dig;
      sh_q   <= SHW'(i_q) + SHW'(j_q);
    end
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

// ===== rtl/core/lmcs_div.sv =====
// ----------------------------------------------------------------------------
// lmcs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lmcs_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [lmcs_pkg::PROD_BITS-1:0]  dividend_i,
  input  logic [lmcs_pkg::STEPS_BITS-1:0] divisor_i,
  output logic                            done_o,
  output logic [lmcs_pkg::PROD_BITS-1:0]  quotient_o
);
  import lmcs_pkg::*;

  localparam int unsigned STW = $clog2(PROD_BITS + 1);

  logic [PROD_BITS-1:0]  dvd_q;
  logic [STEPS_BITS-1:0] dsr_q, rem_q;
  logic [STW-1:0]        step_q;
  logic                  busy_q, done_q;
  logic [STEPS_BITS:0]   rem_sh, rem_new;
  logic                  fits;

  // One restoring step
  always_comb begin
    rem_sh  = {rem_q, dvd_q[PROD_BITS-1]};
    fits    = (rem_sh >= {1'b0, dsr_q});
    rem_new = fits ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STW'(PROD_BITS);
      end else if (busy_q) begin
        step_q <= step_q - STW'(1);
        if (step_q == STW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out, quotient shifts in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[PROD_BITS-2:0], fits};
      rem_q <= rem_new[STEPS_BITS-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ===== rtl/core/lmcs_datapath.sv =====
// ----------------------------------------------------------------------------
// lmcs_datapath
// Configuration registers, rate computation, map iterate registers,
// convergence test and result registers.
// ----------------------------------------------------------------------------
module lmcs_datapath #(
  parameter int unsigned X_FRACTION_BITS = 32,
  parameter int unsigned COUNT_BITS      = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lmcs_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [lmcs_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic [lmcs_pkg::INDEX_BITS-1:0]     point_index_i,
  input  lmcs_pkg::lmcs_cmd_t                 cmd_i,
  output lmcs_pkg::lmcs_status_t              status_o,
  output logic [lmcs_pkg::RATE_BITS-1:0]      rate_value_o,
  output logic [lmcs_pkg::LIMIT_BITS-1:0]     first_count_o,
  output logic                                second_tried_o,
  output logic [lmcs_pkg::LIMIT_BITS-1:0]     second_count_o,
  output logic                                converged_o,
  output logic [lmcs_pkg::FINAL_BITS-1:0]     final_value_o
);
  import lmcs_pkg::*;

  localparam int unsigned F    = X_FRACTION_BITS;
  localparam int unsigned ND   = (F + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int unsigned OPW  = ND * DIGIT_BITS;
  localparam int unsigned PW   = 2 * OPW;
  localparam int unsigned CMPW = (F > 32) ? F : 32;
  localparam int unsigned UP   = (F >= 32) ? (F - 32) : 0;
  localparam int unsigned DOWN = (F < 32) ? (32 - F) : 0;
  localparam int unsigned RSW  = PROD_BITS + 3;
  localparam logic [F-1:0] X_START = F'((64'd4999 << F) / 64'd10000);

  // Configuration
  logic [RATE_BITS-1:0]  sweep_low_q, sweep_high_q;
  logic [STEPS_BITS-1:0] sweep_steps_q;
  logic [LIMIT_BITS-1:0] iter_limit_q;
  logic [TOL_BITS-1:0]   tolerance_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_low_q   <= RST_SWEEP_LOW;
      sweep_high_q  <= RST_SWEEP_HIGH;
      sweep_steps_q <= RST_SWEEP_STEPS;
      iter_limit_q  <= RST_ITER_LIMIT;
      tolerance_q   <= RST_TOLERANCE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SWEEP_LOW:   sweep_low_q   <= cfg_data_i[RATE_BITS-1:0];
        CFG_SWEEP_HIGH:  sweep_high_q  <= cfg_data_i[RATE_BITS-1:0];
        CFG_SWEEP_STEPS: sweep_steps_q <= cfg_data_i[STEPS_BITS-1:0];
        CFG_ITER_LIMIT:  iter_limit_q  <= cfg_data_i[LIMIT_BITS-1:0];
        CFG_TOLERANCE:   tolerance_q   <= cfg_data_i[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Rate: low + (idx * (high - low)) / steps, truncated toward zero, clamped
  logic signed [RATE_BITS:0] diff_s;
  logic [RATE_BITS-1:0]      diff_mag;
  logic [PROD_BITS-1:0]      prod_d, prod_q, quotient;
  logic                      neg_q, div_done;
  logic [STEPS_BITS-1:0]     divisor;
  logic signed [RSW-1:0]     quo_s, rs;
  logic [RSW-1:0]            rs_u;
  logic [RATE_BITS-1:0]      rate_d, rate_q;

  always_comb begin
    diff_s   = $signed({1'b0, sweep_high_q}) - $signed({1'b0, sweep_low_q});
    diff_mag = diff_s[RATE_BITS] ? RATE_BITS'(-diff_s) : diff_s[RATE_BITS-1:0];
    prod_d   = PROD_BITS'(point_index_i) * PROD_BITS'(diff_mag);
    divisor  = (sweep_steps_q == '0) ? STEPS_BITS'(1) : sweep_steps_q;
    quo_s    = neg_q ? -$signed(RSW'(quotient)) : $signed(RSW'(quotient));
    rs       = $signed(RSW'(sweep_low_q)) + quo_s;
    rs_u     = rs;
    if (rs[RSW-1]) begin
      rate_d = '0;
    end else if (rs_u > RSW'(RATE_MAX)) begin
      rate_d = RATE_MAX;
    end else begin
      rate_d = rs_u[RATE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      prod_q <= prod_d;
      neg_q  <= diff_s[RATE_BITS];
    end
  end

  lmcs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Map step: p = x - x*x/2^F, then x' = sat(r * p / 2^29)
  logic [F-1:0]          x_q, last_q, p, x_new, x_mean, diff_x;
  logic [PW-1:0]         mul_p, sub_w, y_w;
  logic [OPW-1:0]        mul_a, mul_b;
  logic                  mul_start, mul_done, sat;
  logic [COUNT_BITS-1:0] cnt_q, c1_q, cnt_limit;
  logic                  tried_q, below_tol;
  logic [CMPW-1:0]       d_ext, tol_ext, x_ext;

  always_comb begin
    sub_w     = (PW'(x_q) << F) - mul_p;
    p         = F'(sub_w >> F);
    mul_start = cmd_i.step_start || cmd_i.scale_start;
    mul_a     = cmd_i.scale_start ? OPW'(p) : OPW'(x_q);
    mul_b     = cmd_i.scale_start ? OPW'(rate_q) : OPW'(x_q);
    y_w       = mul_p >> RATE_FRAC;
    sat       = |(y_w >> F);
    x_new     = sat ? {F{1'b1}} : F'(y_w);
    x_mean    = F'(({1'b0, x_q} + {1'b0, last_q}) >> 1);
    diff_x    = (x_q >= last_q) ? (x_q - last_q) : (last_q - x_q);
    d_ext     = CMPW'(diff_x) << DOWN;
    tol_ext   = CMPW'(tolerance_q) << UP;
    below_tol = (d_ext < tol_ext);
    cnt_limit = COUNT_BITS'(iter_limit_q);
    x_ext     = CMPW'(x_q) << DOWN;
  end

  lmcs_mul #(
    .NUM_DIGITS (ND)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .done_o    (mul_done),
    .product_o (mul_p)
  );

  // Iterate registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.rate_load) begin
      rate_q  <= rate_d;
      x_q     <= X_START;
      last_q  <= '0;
      cnt_q   <= '0;
      tried_q <= 1'b0;
    end else if (cmd_i.restart) begin
      c1_q    <= cnt_q;
      x_q     <= x_mean;
      last_q  <= '0;
      cnt_q   <= '0;
      tried_q <= 1'b1;
    end else if (cmd_i.step_start) begin
      last_q  <= x_q;
      cnt_q   <= cnt_q + COUNT_BITS'(1);
    end else if (cmd_i.x_update) begin
      x_q     <= x_new;
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rate_value_o   <= rate_q;
      first_count_o  <= tried_q ? LIMIT_BITS'(c1_q) : LIMIT_BITS'(cnt_q);
      second_tried_o <= tried_q;
      second_count_o <= tried_q ? LIMIT_BITS'(cnt_q) : '0;
      converged_o    <= below_tol;
      final_value_o  <= x_ext[CMPW-1 -: FINAL_BITS];
    end
  end

  always_comb begin
    status_o.div_done  = div_done;
    status_o.mul_done  = mul_done;
    status_o.below_tol = below_tol;
    status_o.at_limit  = (cnt_q == cnt_limit);
    status_o.tried     = tried_q;
  end

endmodule

// ===== rtl/core/lmcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lmcs_ctrl
// Controller: input and output handshakes, sequencing of rate division,
// map steps and the two convergence attempts.
// ----------------------------------------------------------------------------
module lmcs_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  lmcs_pkg::lmcs_status_t status_i,
  output lmcs_pkg::lmcs_cmd_t    cmd_o
);
  import lmcs_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DIV_START;
        end
      end
      S_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status_i.div_done) begin
          state_d = S_RATE;
        end
      end
      S_RATE: begin
        cmd_o.rate_load = 1'b1;
        state_d         = S_TEST;
      end
      S_TEST: begin
        // loop runs while below limit and not yet within tolerance
        if (!status_i.at_limit && !status_i.below_tol) begin
          cmd_o.step_start = 1'b1;
          state_d          = S_SQUARE;
        end else if (status_i.at_limit && !status_i.tried) begin
          cmd_o.restart = 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SQUARE: begin
        if (status_i.mul_done) begin
          cmd_o.scale_start = 1'b1;
          state_d           = S_SCALE;
        end
      end
      S_SCALE: begin
        if (status_i.mul_done) begin
          cmd_o.x_update = 1'b1;
          state_d        = S_TEST;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid: set on load, cleared when the item is taken
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
